// File: hdl/jdcrl_pkg.sv
package jdcrl_pkg;

	typedef struct packed {
		logic [2:0]         joint_index;
		logic signed [15:0] joint_angle;
		logic signed [19:0] gravity_torque;
		logic               command_stale;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         joint_number;
		logic signed [15:0] command_angle;
	} out_item_t;

	typedef struct packed {
		logic [10:0] stiffness_preset;
		logic [13:0] motor_k;
		logic [13:0] motor_a;
		logic [11:0] normal_rate;
		logic [11:0] stale_rate;
	} cfg_t;

	localparam int unsigned CORDIC_STEPS = 20;
	localparam int unsigned PRESET_MAX = 1229;
	localparam logic signed [63:0] CORDIC_INV_GAIN = 64'sd10188014;

	localparam logic [2:0] REG_PRESET = 3'd0;
	localparam logic [2:0] REG_K      = 3'd1;
	localparam logic [2:0] REG_A      = 3'd2;
	localparam logic [2:0] REG_NRATE  = 3'd3;
	localparam logic [2:0] REG_SRATE  = 3'd4;

	function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
		logic signed [63:0] v;
		unique case (i)
			5'd0:  v = 64'sd13176795;
			5'd1:  v = 64'sd7778716;
			5'd2:  v = 64'sd4110060;
			5'd3:  v = 64'sd2086331;
			5'd4:  v = 64'sd1047214;
			5'd5:  v = 64'sd524117;
			5'd6:  v = 64'sd262123;
			5'd7:  v = 64'sd131069;
			5'd8:  v = 64'sd65536;
			5'd9:  v = 64'sd32768;
			5'd10: v = 64'sd16384;
			5'd11: v = 64'sd8192;
			5'd12: v = 64'sd4096;
			5'd13: v = 64'sd2048;
			5'd14: v = 64'sd1024;
			5'd15: v = 64'sd512;
			5'd16: v = 64'sd256;
			5'd17: v = 64'sd128;
			5'd18: v = 64'sd64;
			5'd19: v = 64'sd32;
			default: v = 64'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/jdcrl_mul.sv
module jdcrl_mul
	import jdcrl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] p
);
	logic [63:0] mcand_q, mplier_q, acc_q;
	logic        neg_q, busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] a_mag, b_mag;

	assign a_mag = a[63] ? 64'(-a) : a;
	assign b_mag = b[63] ? 64'(-b) : b;
	assign p = neg_q ? $signed(64'(-acc_q)) : $signed(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mcand_q <= a_mag;
				mplier_q <= b_mag;
				acc_q <= '0;
				neg_q <= a[63] ^ b[63];
				cnt_q <= '0;
			end else if (busy_q) begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63 || mplier_q[63:1] == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// File: hdl/jdcrl_div.sv
module jdcrl_div
	import jdcrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic        sqrt_mode,
	output logic        done,
	output logic [63:0] res
);
	logic [63:0] v_q, r_q, bit_q, d_q, quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q, sq_q;
	logic [63:0] rem_sh;

	assign rem_sh = {r_q[62:0], v_q[63]};
	assign res = sq_q ? r_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sq_q <= sqrt_mode;
				v_q <= num;
				d_q <= den;
				r_q <= '0;
				quo_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (sq_q) begin
					if (bit_q != '0) begin
						if (v_q >= r_q + bit_q) begin
							v_q <= v_q - (r_q + bit_q);
							r_q <= (r_q >> 1) + bit_q;
						end else
							r_q <= r_q >> 1;
						bit_q <= bit_q >> 2;
					end else begin
						busy_q <= 1'b0;
						done <= 1'b1;
					end
				end else begin
					if (rem_sh >= d_q) begin
						r_q <= rem_sh - d_q;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						r_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					v_q <= v_q << 1;
					if (cnt_q == 7'd63) begin
						busy_q <= 1'b0;
						done <= 1'b1;
					end
				end
			end
		end
	end
endmodule

// File: hdl/joint_deflection_comp_rate_limit_unit.sv
// Joint deflection compensation with slew limiting.
// Input channel (in_valid/in_ready/in_data) takes one joint transaction:
// index, target angle, gravity torque and stale flag. Output channel
// (out_valid/out_ready/out_data) returns one transaction per input: the
// joint number and the slew-limited command angle.
// One item is processed at a time. With a non-zero torque the item passes
// through a 20-step sine/cosine CORDIC, five shift-and-add products, the
// bit-serial square root, a 20-step arctangent CORDIC and the 64-step
// divider before out_valid rises. With zero torque, a stale command or an
// unknown joint the computation is skipped and the item goes from the FIN
// state to OUT, where out_valid rises.
// in_ready is high only while the block is idle; the next item is taken
// once the previous result has been handed over.
// Reset clears all stored previous commands to zero and loads the
// register defaults. A stalled receiver holds out_valid and the result;
// no new item is taken until it is accepted.
// Registers sit on an APB port at byte addresses 0,4,8,12,16.
module joint_deflection_comp_rate_limit_unit
	import jdcrl_pkg::*;
#(
	parameter int NUM_JOINTS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	typedef enum logic [4:0] {
		IDLE, CS, MSC, MC2, MW, MWW, SQ, MNUM, AT, DIVS, FIN, OUT
	} state_t;

	state_t             state_q, prev_state_q;
	cfg_t               cfg_q;
	in_item_t           item_q;
	logic signed [15:0] prev_q [NUM_JOINTS];
	logic signed [63:0] x_q, y_q, z_q, sc_q, c2_q, w_q, den_q;
	logic [4:0]         it_q;
	logic signed [63:0] corr_q;

	logic               mstart, mdone, dstart, ddone, dsq;
	logic signed [63:0] ma, mb, mp;
	logic [63:0]        dn, dd, dres;

	jdcrl_mul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));
	jdcrl_div u_div (.clk, .arst_n, .start(dstart), .num(dn), .den(dd),
		.sqrt_mode(dsq), .done(ddone), .res(dres));

	logic [2:0]  reg_idx;
	logic [10:0] preset_c;
	logic [13:0] a_eff;
	logic [24:0] ang;
	logic [27:0] kk;
	logic        entry;
	logic signed [63:0] k24, ys, xs, tab;
	logic signed [63:0] theta_abs;
	logic signed [26:0] tgt;
	logic signed [17:0] tgt2, prev_e, diff, rate_e, res;
	logic [IW-1:0] jidx;

	assign reg_idx = paddr[4:2];
	assign pready = 1'b1;
	assign preset_c = (cfg_q.stiffness_preset > 11'(PRESET_MAX)) ? 11'(PRESET_MAX)
		: cfg_q.stiffness_preset;
	assign a_eff = (cfg_q.motor_a == '0) ? 14'd1 : cfg_q.motor_a;
	assign ang = cfg_q.motor_a * preset_c;
	assign kk = cfg_q.motor_k * cfg_q.motor_k;
	assign k24 = 64'(cfg_q.motor_k) <<< 12;
	assign ys = y_q >>> it_q;
	assign xs = x_q >>> it_q;
	assign tab = atan_entry(it_q);
	assign theta_abs = z_q[63] ? -z_q : z_q;
	assign jidx = item_q.joint_index[IW-1:0];
	assign entry = (state_q != prev_state_q);

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_PRESET: prdata = 32'(cfg_q.stiffness_preset);
			REG_K:      prdata = 32'(cfg_q.motor_k);
			REG_A:      prdata = 32'(cfg_q.motor_a);
			REG_NRATE:  prdata = 32'(cfg_q.normal_rate);
			REG_SRATE:  prdata = 32'(cfg_q.stale_rate);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		mstart = 1'b0; ma = '0; mb = '0;
		dstart = 1'b0; dn = '0; dd = '0; dsq = 1'b0;
		unique case (state_q)
			MSC:  begin mstart = entry; ma = y_q; mb = x_q; end
			MC2:  begin mstart = entry; ma = x_q; mb = x_q; end
			MW:   begin mstart = entry; ma = 64'(item_q.gravity_torque); mb = sc_q; end
			MWW:  begin mstart = entry; ma = w_q; mb = w_q; end
			MNUM: begin mstart = entry; ma = 64'(item_q.gravity_torque); mb = c2_q; end
			SQ:   begin
				dstart = entry;
				dn = 64'(w_q) + (64'(kk) << 24);
				dsq = 1'b1;
			end
			DIVS: begin
				dstart = entry;
				dn = 64'(theta_abs) + 64'(a_eff >> 1);
				dd = 64'(a_eff);
			end
			default: ;
		endcase
	end

	always_comb begin
		tgt = 27'(item_q.joint_angle) + 27'(corr_q);
		if (tgt > 27'sd32767) tgt = 27'sd32767;
		if (tgt < -27'sd32768) tgt = -27'sd32768;
		if (item_q.joint_index == 3'd3) tgt = -tgt;
		if (tgt > 27'sd32767) tgt = 27'sd32767;
		tgt2 = item_q.command_stale ? 18'sd0 : 18'(tgt);
		rate_e = item_q.command_stale ? 18'(cfg_q.stale_rate) : 18'(cfg_q.normal_rate);
		prev_e = 18'(prev_q[jidx]);
		diff = tgt2 - prev_e;
		if (diff > rate_e) res = prev_e + rate_e;
		else if (diff < -rate_e) res = prev_e - rate_e;
		else res = tgt2;
	end

	assign in_ready = (state_q == IDLE);
	assign out_valid = (state_q == OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			prev_state_q <= IDLE;
			cfg_q <= '{11'd1229, 14'd2048, 14'd8192, 12'd41, 12'd4};
			for (int i = 0; i < NUM_JOINTS; i++) prev_q[i] <= '0;
		end else begin
			prev_state_q <= state_q;
			if (psel && penable && pwrite) begin
				unique case (reg_idx)
					REG_PRESET: cfg_q.stiffness_preset <= pwdata[10:0];
					REG_K:      cfg_q.motor_k <= pwdata[13:0];
					REG_A:      cfg_q.motor_a <= pwdata[13:0];
					REG_NRATE:  cfg_q.normal_rate <= pwdata[11:0];
					REG_SRATE:  cfg_q.stale_rate <= pwdata[11:0];
					default: ;
				endcase
			end
			unique case (state_q)
				IDLE: if (in_valid) begin
					item_q <= in_data;
					corr_q <= '0;
					x_q <= CORDIC_INV_GAIN; y_q <= '0;
					z_q <= 64'(ang);
					it_q <= '0;
					if (in_data.command_stale || in_data.gravity_torque == '0
						|| 32'(in_data.joint_index) >= NUM_JOINTS)
						state_q <= FIN;
					else
						state_q <= CS;
				end
				CS: begin
					if (!z_q[63]) begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - tab;
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + tab;
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CORDIC_STEPS - 1))
						state_q <= MSC;
				end
				MSC: if (mdone) begin sc_q <= mp >>> 24; state_q <= MC2; end
				MC2: if (mdone) begin c2_q <= mp >>> 24; state_q <= MW; end
				MW:  if (mdone) begin w_q <= mp >>> 12; state_q <= MWW; end
				MWW: if (mdone) begin w_q <= mp; state_q <= SQ; end
				SQ:  if (ddone) begin den_q <= k24 + $signed(dres); state_q <= MNUM; end
				MNUM: if (mdone) begin
					x_q <= den_q; y_q <= mp >>> 12; z_q <= '0; it_q <= '0;
					state_q <= AT;
				end
				AT: begin
					if (!y_q[63]) begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + tab;
					end else begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - tab;
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CORDIC_STEPS - 1))
						state_q <= DIVS;
				end
				DIVS: if (ddone) begin
					corr_q <= z_q[63] ? -$signed(dres) : $signed(dres);
					state_q <= FIN;
				end
				FIN: begin
					out_data.joint_number <= item_q.joint_index;
					if (32'(item_q.joint_index) >= NUM_JOINTS)
						out_data.command_angle <= '0;
					else begin
						out_data.command_angle <= res[15:0];
						prev_q[jidx] <= res[15:0];
					end
					state_q <= OUT;
				end
				OUT: if (out_ready) state_q <= IDLE;
				default: ;
			endcase
		end
	end
endmodule

// File: hdl/jdcrl_checker.sv
module jdcrl_checker
	import jdcrl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken with result pending");
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("valid after reset");
endmodule

bind joint_deflection_comp_rate_limit_unit jdcrl_checker u_chk (.clk, .arst_n,
	.in_valid, .in_ready, .out_valid, .out_ready, .out_data);

// File: bench/joint_deflection_comp_rate_limit_unit_tb.sv
`timescale 1ns / 100ps

module joint_deflection_comp_rate_limit_unit_tb;
	import jdcrl_pkg::*;

	localparam int NUM_JOINTS = 5;
	localparam int STALL_LIMIT = 20000;
	localparam longint ATAN_Q24[20] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	joint_deflection_comp_rate_limit_unit #(.NUM_JOINTS(NUM_JOINTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register mirror and per-joint command history
	int unsigned preset_q12, k_q12, a_q12, fresh_step, stale_step;
	longint      last_command[NUM_JOINTS];

	out_item_t   pending_commands[$];
	int          errors;
	int          n_items, n_results, n_stale, n_bad_joint, n_settings;
	int          tx_idle_pct, rx_idle_pct;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint deflection_q12(longint g);
		longint p, a, k24, x, y, z, nx, s, c, sc, c2, w, num, den, theta, mag;
		logic [63:0] v, r, b;
		if (g == 0)
			return 0;
		p = (preset_q12 > PRESET_MAX) ? PRESET_MAX : preset_q12;
		a = (a_q12 == 0) ? 1 : a_q12;
		k24 = longint'(k_q12) <<< 12;
		x = 10188014;
		y = 0;
		z = longint'(a_q12) * p;
		for (int i = 0; i < 20; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q24[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q24[i];
			end
			x = nx;
		end
		s = y;
		c = x;
		sc = (s * c) >>> 24;
		c2 = (c * c) >>> 24;
		w = (g * sc) >>> 12;
		v = 64'(w * w) + 64'(k24 * k24);
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		den = k24 + longint'(r);
		num = (g * c2) >>> 12;
		x = den;
		y = num;
		z = 0;
		for (int i = 0; i < 20; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q24[i];
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q24[i];
			end
			x = nx;
		end
		theta = z;
		mag = ((theta < 0 ? -theta : theta) + (a >>> 1)) / a;
		return theta < 0 ? -mag : mag;
	endfunction

	function automatic out_item_t next_command(in_item_t it);
		out_item_t o;
		longint target, prev, step, res;
		o.joint_number = it.joint_index;
		o.command_angle = '0;
		if (it.joint_index >= NUM_JOINTS)
			return o;
		if (it.command_stale) begin
			target = 0;
			step = stale_step;
		end else begin
			target = longint'(it.joint_angle) + deflection_q12(longint'(it.gravity_torque));
			if (target > 32767) target = 32767;
			if (target < -32768) target = -32768;
			if (it.joint_index == 3) target = -target;
			if (target > 32767) target = 32767;
			step = fresh_step;
		end
		prev = last_command[it.joint_index];
		if (target - prev > step)
			res = prev + step;
		else if (target - prev < -step)
			res = prev - step;
		else
			res = target;
		last_command[it.joint_index] = res;
		o.command_angle = 16'(res);
		return o;
	endfunction

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		out_item_t exp_cmd;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_commands.size() == 0) begin
				$error("unexpected transaction: joint %0d angle %0d",
					out_data.joint_number, out_data.command_angle);
				errors++;
			end else begin
				exp_cmd = pending_commands.pop_front();
				if (out_data.joint_number !== exp_cmd.joint_number) begin
					$error("joint_number: expected %0d, got %0d",
						exp_cmd.joint_number, out_data.joint_number);
					errors++;
				end
				if (out_data.command_angle !== exp_cmd.command_angle) begin
					$error("command_angle: expected %0d, got %0d",
						exp_cmd.command_angle, out_data.command_angle);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d transactions outstanding", pending_commands.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_joint(in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		pending_commands.push_back(next_command(it));
		n_items++;
		if (it.command_stale) n_stale++;
		if (it.joint_index >= NUM_JOINTS) n_bad_joint++;
		@(negedge clk);
	endtask

	task automatic send_fields(int joint, int angle, int torque, bit stale);
		in_item_t it;
		it.joint_index = 3'(joint);
		it.joint_angle = 16'(angle);
		it.gravity_torque = 20'(torque);
		it.command_stale = stale;
		send_joint(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_commands.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, int unsigned value);
		int unsigned mask;
		drain();
		case (index)
			REG_PRESET: begin mask = 32'h7ff;  preset_q12 = value & mask; end
			REG_K:      begin mask = 32'h3fff; k_q12 = value & mask; end
			REG_A:      begin mask = 32'h3fff; a_q12 = value & mask; end
			REG_NRATE:  begin mask = 32'hfff;  fresh_step = value & mask; end
			default:    begin mask = 32'hfff;  stale_step = value & mask; end
		endcase
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {index, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (value & mask)) begin
			$error("register %0d: expected %0d, got %0d", index, value & mask, prdata & mask);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(int unsigned p, int unsigned k, int unsigned a,
			int unsigned nr, int unsigned sr);
		write_reg(REG_PRESET, p);
		write_reg(REG_K, k);
		write_reg(REG_A, a);
		write_reg(REG_NRATE, nr);
		write_reg(REG_SRATE, sr);
		n_settings++;
	endtask

	task automatic test_directed();
		send_fields(0, 0, 0, 0);
		send_fields(1, 32767, 0, 0);
		send_fields(2, -32768, 0, 0);
		send_fields(0, 1000, 524287, 0);
		send_fields(1, -1000, -524288, 0);
		send_fields(3, 32767, 0, 0);
		send_fields(3, -32768, 0, 0);
		send_fields(3, 2000, 300000, 0);
		send_fields(4, 12345, -1, 0);
		send_fields(4, -12345, 1, 0);
		send_fields(0, 500, 1000, 1);
		send_fields(3, -500, -1000, 1);
		send_fields(5, 100, 100, 0);
		send_fields(6, -1, -1, 1);
		send_fields(7, 32767, 524287, 0);
		load_settings(2047, 16383, 16383, 4095, 4095);
		send_fields(0, 32767, 524287, 0);
		send_fields(3, -32768, -524288, 0);
		send_fields(2, 0, 0, 1);
		load_settings(0, 1, 1, 0, 0);
		send_fields(1, 3000, 524287, 0);
		send_fields(1, -3000, -524288, 1);
		load_settings(100, 0, 0, 4095, 17);
		send_fields(4, 32767, 524287, 0);
		send_fields(4, -32768, -524288, 0);
		send_fields(2, 0, 0, 0);
	endtask

	task automatic test_random(int count);
		in_item_t it;
		for (int n = 0; n < count; n++) begin
			if (n % 120 == 0)
				load_settings($urandom_range(1229), $urandom_range(16383, 1),
					$urandom_range(16383, 1), $urandom_range(4095), $urandom_range(4095));
			it.joint_index = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4));
			it.joint_angle = 16'($urandom);
			case ($urandom_range(5))
				0: it.gravity_torque = '0;
				1: it.gravity_torque = 20'($signed($urandom_range(512)) - 256);
				default: it.gravity_torque = 20'($urandom);
			endcase
			it.command_stale = ($urandom_range(9) == 0);
			send_joint(it);
		end
	endtask

	task automatic test_hold_until_empty();
		send_fields(3, 4000, 200000, 0);
		drain();
		send_fields(3, -4000, -200000, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		preset_q12 = 1229; k_q12 = 2048; a_q12 = 8192; fresh_step = 41; stale_step = 4;
		foreach (last_command[j]) last_command[j] = 0;
		errors = 0; n_items = 0; n_results = 0; n_stale = 0; n_bad_joint = 0;
		n_settings = 0; quiet_cycles = 0;
		tx_idle_pct = 18; rx_idle_pct = 45;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(475);
		test_hold_until_empty();
		tx_idle_pct = 45; rx_idle_pct = 18;
		test_random(475);
		tx_idle_pct = 0; rx_idle_pct = 0;
		test_random(475);
		drain();
		repeat (500) @(negedge clk);

		$display("%0d transactions in, %0d out, %0d stale, %0d unknown joint",
			n_items, n_results, n_stale, n_bad_joint);
		$display("%0d register settings applied, %0d mismatches", n_settings, errors);
		if (errors == 0 && pending_commands.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
